// ===== hdl/partition_entry_table_macros.svh =====
// assertion macros shared by the partition entry table files
`ifndef PARTITION_ENTRY_TABLE_MACROS_SVH
`define PARTITION_ENTRY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, checked on every clock edge out of reset
`define PET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define PET_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PET_ASSERT(lbl, clk, rst_n, prop, msg)
`define PET_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hdl/pet_pkg.sv =====
package pet_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int SCAN_W      = ADDR_W + 1;
    localparam int RANK_W      = 8;
    localparam int SEEN_W      = (SCAN_W > RANK_W) ? SCAN_W : RANK_W;
    localparam int COUNT_W     = 8;
    localparam int SLOT_FW     = 7;
    localparam int WORD_W      = 64;
    localparam int TYPE_W      = 2 * WORD_W;
    localparam int LBA_PAIR_W  = 2 * WORD_W;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = ((SLOT_FW + RANK_W + 5 * WORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((SLOT_FW + 4 * WORD_W + 7) / 8) * 8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(128);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_FIND   = 2'd1,
        OP_SHRINK = 2'd2,
        OP_CREATE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NO_FREE   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [SLOT_FW-1:0]  slot;
        logic [RANK_W-1:0]   rank;
        logic [WORD_W-1:0]   type_low;
        logic [WORD_W-1:0]   type_high;
        logic [WORD_W-1:0]   first_lba;
        logic [WORD_W-1:0]   last_lba;
        logic [WORD_W-1:0]   new_last_lba;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [SLOT_FW-1:0]  hit_slot;
        logic [WORD_W-1:0]   hit_type_low;
        logic [WORD_W-1:0]   hit_type_high;
        logic [WORD_W-1:0]   hit_first_lba;
        logic [WORD_W-1:0]   hit_last_lba;
    } t_res;

    typedef struct packed {
        logic                  type_we;
        logic                  lba_we;
        logic [ADDR_W-1:0]     addr;
        logic [TYPE_W-1:0]     type_wd;
        logic [LBA_PAIR_W-1:0] lba_wd;
    } t_mem_wr;

    // result with no entry attached
    function automatic t_res res_none(input t_status status);
        t_res r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

endpackage

// ===== hdl/pet_ram.sv =====
module pet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wd;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/pet_ctrl.sv =====
`include "partition_entry_table_macros.svh"

module pet_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  pet_pkg::t_req                 i_req,
    input  logic [pet_pkg::SCAN_W-1:0]    i_limit,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output pet_pkg::t_res                 o_res,
    output logic [pet_pkg::ADDR_W-1:0]    o_rd_addr,
    input  logic [pet_pkg::TYPE_W-1:0]    i_type_q,
    input  logic [pet_pkg::LBA_PAIR_W-1:0] i_lba_q,
    output pet_pkg::t_mem_wr              o_mem_wr
);
    import pet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CHECK = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state              r_state,  n_state;
    t_req                r_req,    n_req;
    t_res                r_res,    n_res;
    logic [SCAN_W-1:0]   r_lim,    n_lim;
    logic [SCAN_W-1:0]   r_issue,  n_issue;
    logic [SCAN_W-1:0]   r_q_slot, n_q_slot;
    logic [SEEN_W-1:0]   r_seen,   n_seen;
    logic [ADDR_W-1:0]   r_hit,    n_hit;
    t_mem_wr             w_wr;
    logic                w_empty;
    logic [WORD_W-1:0]   w_q_first;
    logic [WORD_W-1:0]   w_q_last;

    assign w_empty   = (i_type_q == '0);
    assign w_q_first = i_lba_q[WORD_W-1:0];
    assign w_q_last  = i_lba_q[LBA_PAIR_W-1:WORD_W];

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_res    = r_res;
        n_lim    = r_lim;
        n_issue  = r_issue;
        n_q_slot = r_q_slot;
        n_seen   = r_seen;
        n_hit    = r_hit;
        w_wr         = '0;
        w_wr.type_wd = {r_req.type_high, r_req.type_low};
        w_wr.lba_wd  = {r_req.last_lba, r_req.first_lba};
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_lim    = i_limit;
                    n_seen   = '0;
                    n_issue  = SCAN_W'(1);
                    n_q_slot = '0;
                    if (i_req.operation == OP_LOAD) begin
                        if (int'(i_req.slot) >= MAX_ENTRIES) begin
                            n_res = res_none(ST_INVALID);
                        end else begin
                            w_wr.type_we = 1'b1;
                            w_wr.lba_we  = 1'b1;
                            w_wr.addr    = ADDR_W'(i_req.slot);
                            w_wr.type_wd = {i_req.type_high, i_req.type_low};
                            w_wr.lba_wd  = {i_req.last_lba, i_req.first_lba};
                            n_res.status        = ST_OK;
                            n_res.hit_slot      = i_req.slot;
                            n_res.hit_type_low  = i_req.type_low;
                            n_res.hit_type_high = i_req.type_high;
                            n_res.hit_first_lba = i_req.first_lba;
                            n_res.hit_last_lba  = i_req.last_lba;
                        end
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // read data on i_*_q belongs to slot r_q_slot
                n_issue  = r_issue + 1'b1;
                n_q_slot = r_issue;
                if (r_q_slot >= r_lim) begin
                    n_res   = res_none((r_req.operation == OP_CREATE) ? ST_NO_FREE
                                                                       : ST_NOT_FOUND);
                    n_state = S_PUSH;
                end else if (r_req.operation == OP_CREATE) begin
                    if (w_empty) begin
                        w_wr.type_we = 1'b1;
                        w_wr.lba_we  = 1'b1;
                        w_wr.addr    = r_q_slot[ADDR_W-1:0];
                        n_res.status        = ST_OK;
                        n_res.hit_slot      = SLOT_FW'(r_q_slot);
                        n_res.hit_type_low  = r_req.type_low;
                        n_res.hit_type_high = r_req.type_high;
                        n_res.hit_first_lba = r_req.first_lba;
                        n_res.hit_last_lba  = r_req.last_lba;
                        n_state = S_PUSH;
                    end
                end else if (!w_empty) begin
                    if (r_seen == SEEN_W'(r_req.rank)) begin
                        n_res.status        = ST_OK;
                        n_res.hit_slot      = SLOT_FW'(r_q_slot);
                        n_res.hit_type_low  = i_type_q[WORD_W-1:0];
                        n_res.hit_type_high = i_type_q[TYPE_W-1:WORD_W];
                        n_res.hit_first_lba = w_q_first;
                        n_res.hit_last_lba  = w_q_last;
                        n_hit   = r_q_slot[ADDR_W-1:0];
                        n_state = (r_req.operation == OP_SHRINK) ? S_CHECK : S_PUSH;
                    end else begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end
            S_CHECK: begin
                // new end must lie strictly inside the current extent
                if (r_req.new_last_lba > r_res.hit_first_lba &&
                    r_req.new_last_lba < r_res.hit_last_lba) begin
                    w_wr.lba_we = 1'b1;
                    w_wr.addr   = r_hit;
                    w_wr.lba_wd = {r_req.new_last_lba, r_res.hit_first_lba};
                    n_res.hit_last_lba = r_req.new_last_lba;
                end else begin
                    n_res.status = ST_INVALID;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_req    <= n_req;
        r_res    <= n_res;
        r_lim    <= n_lim;
        r_issue  <= n_issue;
        r_q_slot <= n_q_slot;
        r_seen   <= n_seen;
        r_hit    <= n_hit;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_PUSH);
    assign o_res       = r_res;
    assign o_rd_addr   = (r_state == S_SCAN) ? r_issue[ADDR_W-1:0] : '0;
    assign o_mem_wr    = w_wr;

    `PET_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_q_slot <= r_lim), "scan slot ran past the limit")
    `PET_ASSERT(a_type_write_src, i_clk, i_rst_n, w_wr.type_we |-> ((r_state == S_SCAN && r_req.operation == OP_CREATE) || (r_state == S_IDLE && i_req_valid && i_req.operation == OP_LOAD)), "type store written outside load or create")
    `PET_ASSERT(a_miss_is_blank, i_clk, i_rst_n, (r_state == S_PUSH && (r_res.status == ST_NOT_FOUND || r_res.status == ST_NO_FREE)) |-> (r_res.hit_slot == '0 && r_res.hit_type_low == '0 && r_res.hit_type_high == '0 && r_res.hit_last_lba == '0), "miss result carries entry data")

endmodule

// ===== hdl/partition_entry_table.sv =====
// result path: a load result goes through the push state and the output register;
//   find and create pass through the scan and push states, shrink also through a
//   check state; the scan ends at the slot that settles it, or at the limit on a miss
// throughput: one transaction at a time, the next is taken in the cycle after the
//   result leaves the scan engine; the scan is set by the single read port of the
//   entry memories, one slot per cycle
// reset: synchronous active-low, entry_count returns to 128; entry memories are not cleared
`include "partition_entry_table_macros.svh"

module partition_entry_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // entry_count register
    input  logic                              i_cfg_we,
    input  logic [pet_pkg::COUNT_W-1:0]       i_cfg_wdata,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot[6:0], rank[14:7], type_low[78:15], type_high[142:79],
    // first_lba[206:143], last_lba[270:207], new_last_lba[334:271], zero pad
    input  logic [pet_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  logic [pet_pkg::OP_W-1:0]          s_axis_tuser,
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit_slot[6:0], hit_type_low[70:7], hit_type_high[134:71],
    // hit_first_lba[198:135], hit_last_lba[262:199], zero pad
    output logic [pet_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [pet_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import pet_pkg::*;

    localparam int P0 = SLOT_FW;
    localparam int P1 = P0 + RANK_W;
    localparam int P2 = P1 + WORD_W;
    localparam int P3 = P2 + WORD_W;
    localparam int P4 = P3 + WORD_W;
    localparam int P5 = P4 + WORD_W;
    localparam int P6 = P5 + WORD_W;

    // header slot count, clamped to the table size before scanning
    logic [COUNT_W-1:0]    r_entry_count;
    logic [SCAN_W-1:0]     w_limit;

    // output register decouples the scan engine from the result consumer
    logic                  r_m_valid;
    t_res                  r_m_res;

    t_req                  w_req;
    logic                  w_req_ready;
    logic                  w_res_valid;
    logic                  w_res_ready;
    t_res                  w_res;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [TYPE_W-1:0]     w_type_q;
    logic [LBA_PAIR_W-1:0] w_lba_q;
    t_mem_wr               w_mem_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    assign w_limit = (int'(r_entry_count) > MAX_ENTRIES) ? SCAN_W'(MAX_ENTRIES)
                                                          : SCAN_W'(r_entry_count);

    // unpack the request transaction
    always_comb begin
        w_req.operation    = t_op'(s_axis_tuser);
        w_req.slot         = s_axis_tdata[P0-1:0];
        w_req.rank         = s_axis_tdata[P1-1:P0];
        w_req.type_low     = s_axis_tdata[P2-1:P1];
        w_req.type_high    = s_axis_tdata[P3-1:P2];
        w_req.first_lba    = s_axis_tdata[P4-1:P3];
        w_req.last_lba     = s_axis_tdata[P5-1:P4];
        w_req.new_last_lba = s_axis_tdata[P6-1:P5];
    end

    assign s_axis_tready = w_req_ready;

    pet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .i_limit     (w_limit),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_rd_addr   (w_rd_addr),
        .i_type_q    (w_type_q),
        .i_lba_q     (w_lba_q),
        .o_mem_wr    (w_mem_wr)
    );

    // type identifier store: {type_high, type_low}
    pet_ram #(
        .WIDTH (TYPE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_type_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem_wr.type_we),
        .i_wr_addr (w_mem_wr.addr),
        .i_wd      (w_mem_wr.type_wd),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_type_q)
    );

    // block range store: {last_lba, first_lba}
    pet_ram #(
        .WIDTH (LBA_PAIR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_lba_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem_wr.lba_we),
        .i_wr_addr (w_mem_wr.addr),
        .i_wd      (w_mem_wr.lba_wd),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_lba_q)
    );

    // take a new result whenever the output slot is empty or draining
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = OUT_DATA_W'({r_m_res.hit_last_lba, r_m_res.hit_first_lba,
                                        r_m_res.hit_type_high, r_m_res.hit_type_low,
                                        r_m_res.hit_slot});

    `PET_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_res_valid && w_res_ready, r_m_valid, "handed-off result missing from output register")

endmodule
